>>> hdl/ckf_pkg.sv
// Shared types and constants for the speed Kalman filter core.
// No dependencies; imported by every module in hdl/.
`timescale 1ns / 1ps

package ckf_pkg;

  localparam int ID_W    = 11;
  localparam int BYTE_W  = 8;
  localparam int NOISE_W = 24;
  localparam int FX_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [ID_W-1:0]    MATCH_ID_RST   = 11'd256;
  localparam logic [NOISE_W-1:0] PROC_NOISE_RST = 24'd655;
  localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = 24'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_ID   = 2'd0,
    CFG_PROC_NOISE = 2'd1,
    CFG_MEAS_NOISE = 2'd2
  } ckf_cfg_idx_e;

  typedef struct packed {
    logic [ID_W-1:0]    match_id;
    logic [NOISE_W-1:0] process_noise;
    logic [NOISE_W-1:0] measurement_noise;
  } ckf_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ckf_q_stat_t;

endpackage

>>> hdl/can_speed_kalman_filter_core.sv
// Speed Kalman filter core: frames accepted every cycle while the 2-entry queue has room.
// The back end takes one matching frame at a time from the queue and takes the next one only
// after the last has reached the result slot. Each step runs through the serial gain divider
// (one quotient bit per cycle) and three passes through one shared multiplier.
// Async active-low reset: estimate 0, covariance 1.0, registers 256/655/6554, queue empty.
// Depends on ckf_pkg, ckf_front, ckf_queue, ckf_back.
`timescale 1ns / 1ps

module can_speed_kalman_filter_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ckf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ckf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [ckf_pkg::ID_W-1:0]       frame_id_i,
  input  logic [ckf_pkg::BYTE_W-1:0]     data_hi_i,
  input  logic [ckf_pkg::BYTE_W-1:0]     data_lo_i,
  input  logic                          pop,
  output logic                          empty,
  output logic [ckf_pkg::FX_W-1:0]       filtered_speed_o,
  output logic                          speed_changed_o
);
  import ckf_pkg::*;

  ckf_cfg_t        cfg_q;
  ckf_q_stat_t     q_stat;
  logic            q_push, q_pop, busy;
  logic [FX_W-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_id          <= MATCH_ID_RST;
      cfg_q.process_noise     <= PROC_NOISE_RST;
      cfg_q.measurement_noise <= MEAS_NOISE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MATCH_ID:   cfg_q.match_id          <= cfg_data_i[ID_W-1:0];
        CFG_PROC_NOISE: cfg_q.process_noise     <= cfg_data_i[NOISE_W-1:0];
        CFG_MEAS_NOISE: cfg_q.measurement_noise <= cfg_data_i[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  ckf_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .push_i     (push),
    .frame_id_i (frame_id_i),
    .data_hi_i  (data_hi_i),
    .data_lo_i  (data_lo_i),
    .cfg_i      (cfg_q),
    .q_stat_i   (q_stat),
    .full_o     (full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  ckf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .stat_o (q_stat),
    .data_o (q_rdata)
  );

  ckf_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_stat_i         (q_stat),
    .q_data_i         (q_rdata),
    .q_pop_o          (q_pop),
    .busy_o           (busy),
    .pop_i            (pop),
    .empty_o          (empty),
    .filtered_speed_o (filtered_speed_o),
    .speed_changed_o  (speed_changed_o)
  );

`ifndef SYNTHESIS
  a_push_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (push && !full && (frame_id_i == cfg_q.match_id)))
    else $error("queue write without an accepted matching frame");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("back end read from an empty queue");

  a_result_from_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(busy))
    else $error("result appeared without a filter step");
`endif

endmodule

>>> hdl/ckf_front.sv
// Front end: filters frames by identifier and forms the fixed-point measurement.
// Depends on ckf_pkg.
`timescale 1ns / 1ps

module ckf_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      push_i,
  input  logic [ckf_pkg::ID_W-1:0]   frame_id_i,
  input  logic [ckf_pkg::BYTE_W-1:0] data_hi_i,
  input  logic [ckf_pkg::BYTE_W-1:0] data_lo_i,
  input  ckf_pkg::ckf_cfg_t          cfg_i,
  input  ckf_pkg::ckf_q_stat_t       q_stat_i,
  output logic                      full_o,
  output logic                      q_push_o,
  output logic [ckf_pkg::FX_W-1:0]   q_data_o
);
  import ckf_pkg::*;

  logic [2*BYTE_W-1:0] speed;
  logic [47:0]         z_wide;

  assign speed    = {data_hi_i, data_lo_i};
  assign z_wide   = 48'(speed) << FRAC_BITS;
  assign q_data_o = (|z_wide[47:FX_W]) ? '1 : z_wide[FX_W-1:0];
  assign full_o   = q_stat_i.full;
  assign q_push_o = push_i && !q_stat_i.full && (frame_id_i == cfg_i.match_id);

endmodule

>>> hdl/ckf_queue.sv
// Two-entry measurement queue between front and back end.
// Depends on ckf_pkg.
`timescale 1ns / 1ps

module ckf_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [ckf_pkg::FX_W-1:0] data_i,
  input  logic                    pop_i,
  output ckf_pkg::ckf_q_stat_t     stat_o,
  output logic [ckf_pkg::FX_W-1:0] data_o
);
  import ckf_pkg::*;

  logic [FX_W-1:0]    mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/ckf_back.sv
// Back end: filter state, serial gain divider, shared multiplier, result slot.
// Depends on ckf_pkg.
`timescale 1ns / 1ps

module ckf_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ckf_pkg::ckf_cfg_t        cfg_i,
  input  ckf_pkg::ckf_q_stat_t     q_stat_i,
  input  logic [ckf_pkg::FX_W-1:0] q_data_i,
  output logic                    q_pop_o,
  output logic                    busy_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output logic [ckf_pkg::FX_W-1:0] filtered_speed_o,
  output logic                    speed_changed_o
);
  import ckf_pkg::*;

  localparam int GW = FRAC_BITS + 1;
  localparam int PW = GW + FX_W;
  localparam int CW = $clog2(GW);
  localparam logic [CW-1:0] LastCnt = CW'(GW - 1);
  localparam logic [GW-1:0] OneG    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0] HalfP   = PW'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_DIV, ST_KEEP, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_DONE
  } state_e;

  state_e          state_q;
  logic [FX_W-1:0] est_q, cov_q, z_q, p1_q;
  logic [FX_W:0]   den_q;
  logic [FX_W+1:0] rem_q;
  logic [GW-1:0]   gain_q, keep_q;
  logic [CW-1:0]   cnt_q;
  logic [PW-1:0]   prod_q, acc_q;
  logic            out_valid_q, out_changed_q;
  logic [FX_W-1:0] out_speed_q;

  logic [FX_W:0]   p1_sum, den_sum, est_w;
  logic [FX_W-1:0] p1_sat, est_sat, mul_b;
  logic [FX_W+1:0] rem_sub, rem_nxt;
  logic            rem_ge, den_zero, out_free;
  logic [GW-1:0]   mul_a;
  logic [PW-1:0]   prod_w;

  assign p1_sum   = {1'b0, cov_q} + (FX_W + 1)'(cfg_i.process_noise);
  assign p1_sat   = p1_sum[FX_W] ? '1 : p1_sum[FX_W-1:0];
  assign den_sum  = {1'b0, p1_q} + (FX_W + 1)'(cfg_i.measurement_noise);
  assign den_zero = (den_q == '0);

  assign rem_ge  = (rem_q >= {1'b0, den_q});
  assign rem_sub = rem_q - {1'b0, den_q};
  assign rem_nxt = rem_ge ? rem_sub : rem_q;

  always_comb begin
    unique case (state_q)
      ST_MUL_A: begin
        mul_a = keep_q;
        mul_b = est_q;
      end
      ST_MUL_B: begin
        mul_a = gain_q;
        mul_b = z_q;
      end
      default: begin
        mul_a = keep_q;
        mul_b = p1_q;
      end
    endcase
  end

  assign prod_w  = mul_a * mul_b;
  assign est_w   = acc_q[PW-1:FRAC_BITS];
  assign est_sat = est_w[FX_W] ? '1 : est_w[FX_W-1:0];
  assign out_free = !out_valid_q || pop_i;

  assign q_pop_o = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign busy_o  = (state_q != ST_IDLE);
  assign empty_o = !out_valid_q;
  assign filtered_speed_o = out_speed_q;
  assign speed_changed_o  = out_changed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      est_q         <= '0;
      cov_q         <= FX_W'(OneG);
      out_valid_q   <= 1'b0;
      cnt_q         <= '0;
      z_q           <= '0;
      p1_q          <= '0;
      den_q         <= '0;
      rem_q         <= '0;
      gain_q        <= '0;
      keep_q        <= '0;
      prod_q        <= '0;
      acc_q         <= '0;
      out_speed_q   <= '0;
      out_changed_q <= 1'b0;
    end else begin
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_stat_i.empty) begin
            z_q     <= q_data_i;
            p1_q    <= p1_sat;
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          den_q   <= den_sum;
          rem_q   <= {1'b0, p1_q};
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q  <= {rem_nxt[FX_W:0], 1'b0};
          gain_q <= {gain_q[GW-2:0], rem_ge};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == LastCnt) begin
            state_q <= ST_KEEP;
          end
        end
        ST_KEEP: begin
          gain_q  <= den_zero ? '0 : gain_q;
          keep_q  <= den_zero ? OneG : OneG - gain_q;
          state_q <= ST_MUL_A;
        end
        ST_MUL_A: begin
          prod_q  <= prod_w;
          state_q <= ST_MUL_B;
        end
        ST_MUL_B: begin
          acc_q   <= prod_q + HalfP;
          prod_q  <= prod_w;
          state_q <= ST_MUL_C;
        end
        ST_MUL_C: begin
          acc_q   <= acc_q + prod_q;
          prod_q  <= prod_w;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_speed_q   <= est_sat;
            out_changed_q <= (est_sat != est_q);
            out_valid_q   <= 1'b1;
            est_q         <= est_sat;
            cov_q         <= prod_q[FRAC_BITS+FX_W-1:FRAC_BITS];
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
